// ===== design/frt_pkg.sv =====
// Package for the fragment reassembly tracker: status codes, constants, types.
// No dependencies.
package frt_pkg;
  localparam int unsigned ContextsDefault = 64;
  localparam int unsigned MaxFragsDefault = 256;
  localparam logic [31:0] FragMagic = 32'h4D4F4E54;
  localparam logic [15:0] FragHdrLen = 16'd20;
  localparam logic [15:0] FragSizeReset = 16'd4096;
  localparam logic [31:0] TimeoutReset = 32'd30000;

  typedef enum logic [2:0] {
    StPass = 3'd0, StStored = 3'd1, StDup = 3'd2, StComplete = 3'd3,
    StFull = 3'd4, StBad = 3'd5, StSweep = 3'd6
  } status_e;

  typedef enum logic [0:0] {RegFragSize = 1'b0, RegTimeout = 1'b1} cfg_reg_e;

  typedef struct packed {
    logic        action;
    logic [15:0] conn_id;
    logic [15:0] content_len;
    logic [31:0] magic_word;
    logic [31:0] frag_msg_id;
    logic [15:0] total_frags;
    logic [15:0] frag_index;
    logic [23:0] total_len;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        write_enable;
    logic [23:0] write_offset;
    logic [15:0] write_len;
    logic [23:0] complete_len;
    logic [6:0]  expired_count;
  } out_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_t;
endpackage

// ===== design/frt_if.sv =====
// Valid/ready channel interface carrying one payload type.
// No dependencies; the payload type is given as a parameter.
interface frt_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker: context table in synchronous memories with a
// sequential scan engine. Depends on frt_pkg and frt_if.
// Each transaction is handled alone. A message header takes one scan of the context
// memory, one entry per cycle, plus a bitmap read-modify-write; a header that
// allocates a new context also clears that context's bitmap; a sweep takes one scan
// of the context memory; pass-through goes straight to the result.
// After reset a clearing pass runs over the context memory before the first
// transaction is taken. The result stays in an output register until taken.
module fragment_reassembly_tracker import frt_pkg::*; #(
  parameter int unsigned CONTEXTS  = ContextsDefault,
  parameter int unsigned MAX_FRAGS = MaxFragsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  frt_if.sink   in_i,
  frt_if.source out_o,
  frt_if.sink   cfg_i
);
  localparam int unsigned SW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned FW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAGS + 1);
  localparam int unsigned BW = SW + FW;

  typedef struct packed {
    logic          in_use;
    logic [15:0]   conn;
    logic [31:0]   msg_id;
    logic [CW-1:0] total_frags;
    logic [23:0]   total_len;
    logic [CW-1:0] received;
    logic [31:0]   created;
  } ctx_t;

  typedef enum logic [8:0] {
    SClear = 9'b000000001, SIdle = 9'b000000010, SScan = 9'b000000100,
    SEval = 9'b000001000, SBmRd = 9'b000010000, SBmWait = 9'b000100000,
    SBmClr = 9'b001000000, SDone = 9'b010000000, SMul = 9'b100000000
  } state_e;

  ctx_t ctx_mem [CONTEXTS];
  logic bm_mem [2**BW];

  state_e        state_q, state_d;
  in_t           req_q;
  out_t          res_q;
  logic          res_vld_q;
  logic [15:0]   fsize_q;
  logic [31:0]   tmo_q;
  logic [SW:0]   addr_q;
  logic [SW-1:0] rd_slot_q;
  logic          rd_vld_q;
  ctx_t          rd_q;
  logic          hit_q, free_q;
  logic [SW-1:0] hit_slot_q, free_slot_q;
  logic [6:0]    freed_q;
  logic [SW-1:0] slot_q;
  ctx_t          ctx_q;
  logic          bm_q;
  logic [FW:0]   clr_q;
  logic [39:0]   prod_q;

  logic ctx_we;
  logic [SW-1:0] ctx_wa;
  ctx_t ctx_wd;
  logic bm_we;
  logic [BW-1:0] bm_wa;
  logic bm_wd;

  wire is_frag = (req_q.content_len >= FragHdrLen) && (req_q.magic_word == FragMagic);
  wire idx_ok_new = (req_q.total_frags != 16'd0) &&
    ({16'd0, req_q.total_frags} <= 32'(MAX_FRAGS)) && (req_q.frag_index < req_q.total_frags);
  wire rd_match = rd_q.in_use && rd_q.conn == req_q.conn_id && rd_q.msg_id == req_q.frag_msg_id;
  wire [31:0] age = req_q.now_ms - rd_q.created;
  wire [BW-1:0] bm_addr = {slot_q, req_q.frag_index[FW-1:0]};
  wire [CW-1:0] rcv_next = ctx_q.received + CW'(1);
  wire bad_known = ({16'd0, req_q.frag_index} >= 32'(rd_q.total_frags)) ||
    ({16'd0, req_q.frag_index} >= 32'(MAX_FRAGS));

  assign in_i.ready  = (state_q == SIdle) && !res_vld_q;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i) begin
    if (ctx_we) ctx_mem[ctx_wa] <= ctx_wd;
    rd_q <= ctx_mem[addr_q[SW-1:0]];
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_q <= bm_mem[bm_addr];
  end

  always_comb begin
    state_d = state_q;
    ctx_we = 1'b0;
    ctx_wa = rd_slot_q;
    ctx_wd = rd_q;
    bm_we = 1'b0;
    bm_wa = bm_addr;
    bm_wd = 1'b1;
    unique case (state_q)
      SClear: begin
        ctx_we = 1'b1;
        ctx_wa = addr_q[SW-1:0];
        ctx_wd = '0;
        if (addr_q == (SW+1)'(CONTEXTS - 1)) state_d = SIdle;
      end
      SIdle: if (in_i.valid && in_i.ready) state_d = SScan;
      SScan: begin
        if (!req_q.action && !is_frag) state_d = SDone;
        else begin
          if (rd_vld_q && req_q.action && rd_q.in_use && age > tmo_q) begin
            ctx_we = 1'b1;
            ctx_wd.in_use = 1'b0;
          end
          if (rd_vld_q && rd_slot_q == SW'(CONTEXTS - 1)) state_d = req_q.action ? SDone : SEval;
        end
      end
      SEval: state_d = SBmRd;
      SBmRd: state_d = SBmWait;
      SBmWait: begin
        if (!hit_q && (!idx_ok_new || !free_q)) state_d = SDone;
        else if (hit_q && (bad_known || bm_q)) state_d = SDone;
        else if (!hit_q) state_d = SBmClr;
        else state_d = SMul;
      end
      SBmClr: begin
        bm_we = 1'b1;
        bm_wa = {slot_q, clr_q[FW-1:0]};
        bm_wd = 1'b0;
        if (clr_q == (FW+1)'(MAX_FRAGS - 1)) state_d = SMul;
      end
      SMul: begin
        bm_we = 1'b1;
        ctx_we = 1'b1;
        ctx_wa = slot_q;
        ctx_wd = '{in_use: (rcv_next != ctx_q.total_frags), conn: ctx_q.conn,
                   msg_id: ctx_q.msg_id, total_frags: ctx_q.total_frags,
                   total_len: ctx_q.total_len, received: rcv_next,
                   created: ctx_q.created};
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      res_vld_q <= 1'b0;
      fsize_q <= FragSizeReset;
      tmo_q <= TimeoutReset;
      addr_q <= '0;
      rd_vld_q <= 1'b0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      freed_q <= '0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.data.index == RegFragSize) fsize_q <= cfg_i.data.data[15:0];
        else tmo_q <= cfg_i.data.data;
      end
      if (out_o.valid && out_o.ready) res_vld_q <= 1'b0;
      rd_vld_q <= ((state_q == SIdle) && in_i.valid && in_i.ready) ||
                  ((state_q == SScan) && (addr_q < (SW+1)'(CONTEXTS)));
      case (state_q)
        SClear: addr_q <= addr_q + 1'b1;
        SIdle: begin
          addr_q <= (in_i.valid && in_i.ready) ? (SW+1)'(1) : '0;
          hit_q <= 1'b0;
          free_q <= 1'b0;
          freed_q <= '0;
          if (in_i.valid && in_i.ready) begin
            req_q <= in_i.data;
            rd_slot_q <= '0;
          end
        end
        SScan: begin
          if (addr_q < (SW+1)'(CONTEXTS)) addr_q <= addr_q + 1'b1;
          if (rd_vld_q) begin
            rd_slot_q <= rd_slot_q + 1'b1;
            if (req_q.action && rd_q.in_use && age > tmo_q) freed_q <= freed_q + 7'd1;
            if (!hit_q && rd_match) begin
              hit_q <= 1'b1;
              hit_slot_q <= rd_slot_q;
            end
            if (!free_q && !rd_q.in_use) begin
              free_q <= 1'b1;
              free_slot_q <= rd_slot_q;
            end
          end
        end
        SEval: begin
          res_q <= '0;
          prod_q <= {8'd0, req_q.frag_index} * {24'd0, fsize_q};
          if (hit_q) begin
            slot_q <= hit_slot_q;
            addr_q <= {1'b0, hit_slot_q};
          end else begin
            slot_q <= free_slot_q;
            ctx_q <= '{in_use: 1'b1, conn: req_q.conn_id, msg_id: req_q.frag_msg_id,
                       total_frags: CW'(req_q.total_frags), total_len: req_q.total_len,
                       received: '0, created: req_q.now_ms};
          end
          clr_q <= '0;
        end
        SBmRd: ;
        SBmWait: if (hit_q) ctx_q <= rd_q;
        SBmClr: clr_q <= clr_q + 1'b1;
        SMul: ;
        SDone: ;
        default: ;
      endcase
      if (state_q == SBmWait) begin
        if (!hit_q && !idx_ok_new) begin
          res_q <= '{status: StBad, default: '0};
        end else if (!hit_q && !free_q) begin
          res_q <= '{status: StFull, default: '0};
        end else if (hit_q && bad_known) begin
          res_q <= '{status: StBad, slot: 6'(slot_q), default: '0};
        end else if (hit_q && bm_q) begin
          res_q <= '{status: StDup, slot: 6'(slot_q), default: '0};
        end
      end
      if (state_q == SMul) begin
        res_q.slot <= 6'(slot_q);
        res_q.write_enable <= 1'b1;
        res_q.write_len <= req_q.content_len - FragHdrLen;
        res_q.write_offset <= prod_q[23:0];
        res_q.expired_count <= '0;
        if (rcv_next == ctx_q.total_frags) begin
          res_q.status <= StComplete;
          res_q.complete_len <= ctx_q.total_len;
        end else begin
          res_q.status <= StStored;
          res_q.complete_len <= '0;
        end
      end
      if (state_q == SDone) begin
        res_vld_q <= 1'b1;
        if (req_q.action) res_q <= '{status: StSweep, expired_count: freed_q, default: '0};
        else if (!is_frag) res_q <= '{status: StPass, default: '0};
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == SIdle)) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !out_o.ready) |=> res_vld_q) else $error("result dropped");
  a_we_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.write_enable) |->
      (res_q.status == StStored || res_q.status == StComplete)) else $error("bad write");
endmodule

// ===== bench/fragment_reassembly_tracker_test.sv =====
// Testbench for the fragment reassembly tracker: drives headers, sweeps and
// register writes, predicts each result and checks it. Depends on frt_pkg, frt_if and the tracker.
module fragment_reassembly_tracker_test;
  import frt_pkg::*;

  class frag_scoreboard;
    logic [15:0] frag_size;
    logic [31:0] timeout;
    bit          used[64];
    logic [15:0] conn[64];
    logic [31:0] msg_id[64];
    int unsigned tfrags[64];
    logic [23:0] tlen[64];
    int unsigned rcvd[64];
    logic [31:0] created[64];
    bit          seen[64][256];
    out_t        pending[$];
    int          errors;
    int          n_complete;
    int          n_sweep_freed;

    function void reset_state();
      frag_size = FragSizeReset;
      timeout = TimeoutReset;
      foreach (used[i]) used[i] = 0;
      errors = 0;
      n_complete = 0;
      n_sweep_freed = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      if (idx == RegFragSize) frag_size = val[15:0];
      else timeout = val;
    endfunction

    function int live_slots();
      int n;
      n = 0;
      foreach (used[i]) if (used[i]) n++;
      return n;
    endfunction

    function void note_header(in_t it);
      out_t r;
      int s;
      logic [31:0] age;
      logic [39:0] prod;
      r = '0;
      s = -1;
      if (it.action) begin
        r.status = StSweep;
        for (int i = 0; i < 64; i++) begin
          age = it.now_ms - created[i];
          if (used[i] && age > timeout) begin
            used[i] = 0;
            r.expired_count++;
          end
        end
        n_sweep_freed += r.expired_count;
        pending.push_back(r);
        return;
      end
      if (it.content_len < FragHdrLen || it.magic_word != FragMagic) begin
        r.status = StPass;
        pending.push_back(r);
        return;
      end
      for (int i = 0; i < 64; i++)
        if (s < 0 && used[i] && conn[i] == it.conn_id && msg_id[i] == it.frag_msg_id) s = i;
      if (s < 0) begin
        if (it.total_frags == 0 || it.total_frags > 256 || it.frag_index >= it.total_frags) begin
          r.status = StBad;
          pending.push_back(r);
          return;
        end
        for (int i = 0; i < 64; i++) if (s < 0 && !used[i]) s = i;
        if (s < 0) begin
          r.status = StFull;
          pending.push_back(r);
          return;
        end
        used[s] = 1;
        conn[s] = it.conn_id;
        msg_id[s] = it.frag_msg_id;
        tfrags[s] = it.total_frags;
        tlen[s] = it.total_len;
        rcvd[s] = 0;
        created[s] = it.now_ms;
        for (int k = 0; k < 256; k++) seen[s][k] = 0;
      end else if (it.frag_index >= tfrags[s]) begin
        r.status = StBad;
        r.slot = 6'(s);
        pending.push_back(r);
        return;
      end
      r.slot = 6'(s);
      if (seen[s][it.frag_index]) begin
        r.status = StDup;
        pending.push_back(r);
        return;
      end
      seen[s][it.frag_index] = 1;
      rcvd[s]++;
      prod = it.frag_index * frag_size;
      r.write_enable = 1;
      r.write_offset = prod[23:0];
      r.write_len = it.content_len - FragHdrLen;
      if (rcvd[s] == tfrags[s]) begin
        used[s] = 0;
        r.status = StComplete;
        r.complete_len = tlen[s];
        n_complete++;
      end else r.status = StStored;
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) report("status", exp.status, got.status);
      if (got.slot != exp.slot) report("slot", exp.slot, got.slot);
      if (got.write_enable != exp.write_enable)
        report("write_enable", exp.write_enable, got.write_enable);
      if (got.write_offset != exp.write_offset)
        report("write_offset", exp.write_offset, got.write_offset);
      if (got.write_len != exp.write_len) report("write_len", exp.write_len, got.write_len);
      if (got.complete_len != exp.complete_len)
        report("complete_len", exp.complete_len, got.complete_len);
      if (got.expired_count != exp.expired_count)
        report("expired_count", exp.expired_count, got.expired_count);
    endfunction

    function void report(string fld, logic [31:0] exp, logic [31:0] got);
      $display("%0t: %s expected %0h actual %0h", $time, fld, exp, got);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  frt_if #(.payload_t(in_t))  in_ch  ();
  frt_if #(.payload_t(out_t)) out_ch ();
  frt_if #(.payload_t(cfg_t)) cfg_ch ();

  fragment_reassembly_tracker i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  frag_scoreboard sb;
  bit          quiet_mode;
  bit          hold_off;
  bit          stim_done;
  int          n_sent;
  int          n_results;
  int          idle_cycles;
  logic [31:0] clock_ms;
  logic [15:0] active_conn[$];
  logic [31:0] active_msg[$];
  int unsigned active_total[$];

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic bit roll_idle();
    return !quiet_mode && ($urandom_range(99) < 16);
  endfunction

  task automatic send_header(in_t it);
    while (roll_idle()) @(negedge clk_i);
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_header(it);
    n_sent++;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_t c;
    c.index = idx;
    c.data = val;
    cfg_ch.data <= c;
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic in_t frag(logic [15:0] cid, logic [31:0] mid, logic [15:0] tot,
                               logic [15:0] idx);
    in_t it;
    it = '0;
    it.conn_id = cid;
    it.frag_msg_id = mid;
    it.total_frags = tot;
    it.frag_index = idx;
    it.magic_word = FragMagic;
    it.content_len = 16'($urandom_range(65535, 20));
    it.total_len = 24'($urandom);
    clock_ms += $urandom_range(200);
    it.now_ms = clock_ms;
    return it;
  endfunction

  function automatic in_t sweep_at(logic [31:0] t);
    in_t it;
    it = '0;
    it.action = 1'b1;
    it.now_ms = t;
    return it;
  endfunction

  task automatic directed_part();
    in_t it;
    it = frag(16'hFFFF, 32'hFFFF_FFFF, 16'd2, 16'd1);
    it.content_len = 16'd20;
    send_header(it);
    it = frag(16'hFFFF, 32'hFFFF_FFFF, 16'd9, 16'd1);
    send_header(it);
    it = frag(16'hFFFF, 32'hFFFF_FFFF, 16'd9, 16'd5);
    send_header(it);
    it = frag(16'hFFFF, 32'hFFFF_FFFF, 16'd9, 16'd0);
    it.content_len = 16'hFFFF;
    send_header(it);
    it = frag(16'd0, 32'd0, 16'd0, 16'd0);
    send_header(it);
    it = frag(16'd0, 32'd0, 16'd257, 16'd0);
    send_header(it);
    it = frag(16'd0, 32'd0, 16'd5, 16'd5);
    send_header(it);
    it = frag(16'd0, 32'd0, 16'd256, 16'd255);
    send_header(it);
    it = frag(16'd0, 32'd0, 16'd1, 16'd300);
    send_header(it);
    it = frag(16'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    send_header(it);
    it = frag(16'd1, 32'd7, 16'd1, 16'd0);
    send_header(it);
    it = frag(16'd1, 32'd7, 16'd1, 16'd0);
    it.content_len = 16'd19;
    send_header(it);
    it.content_len = 16'd40;
    it.magic_word = ~FragMagic;
    send_header(it);
    it.magic_word = FragMagic ^ 32'h1;
    send_header(it);
    for (int i = 0; i < 64; i++) send_header(frag(16'd2, i, 16'd2, 16'd0));
    send_header(frag(16'd3, 32'd99, 16'd2, 16'd0));
    send_header(sweep_at(clock_ms));
    send_header(sweep_at(clock_ms + 32'hFFFF_0000));
  endtask

  task automatic random_part(int count);
    in_t it;
    int k;
    logic [191:0] raw;
    repeat (count) begin
      k = $urandom_range(99);
      if (k < 70 && (active_conn.size() == 0 || $urandom_range(3) == 0)
          && active_conn.size() < 40) begin
        active_conn.push_back(16'($urandom_range(7)));
        active_msg.push_back($urandom);
        active_total.push_back($urandom_range(1, 6));
      end
      if (k < 70 && active_conn.size() != 0) begin
        int j;
        j = $urandom_range(active_conn.size() - 1);
        it = frag(active_conn[j], active_msg[j], 16'(active_total[j]),
                  16'($urandom_range(active_total[j] - ($urandom_range(9) == 0 ? 0 : 1))));
        send_header(it);
        if ($urandom_range(5) == 0) begin
          active_conn.delete(j);
          active_msg.delete(j);
          active_total.delete(j);
        end
      end else if (k < 80) begin
        it = sweep_at(clock_ms + $urandom_range(3000));
        if ($urandom_range(7) == 0) it.now_ms = $urandom;
        send_header(it);
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_t)-1:0];
        it.action = 1'b0;
        if ($urandom_range(1)) it.magic_word = FragMagic;
        send_header(it);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    quiet_mode = 0;
    hold_off = 0;
    stim_done = 0;
    n_sent = 0;
    clock_ms = 32'hFFFF_F000;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_part();
    drain();
    write_reg(RegFragSize, 32'd0);
    write_reg(RegTimeout, 32'd0);
    random_part(150);
    drain();
    write_reg(RegFragSize, 32'hFFFF);
    write_reg(RegTimeout, 32'hFFFF_FFFF);
    hold_off = 1;
    random_part(150);
    drain();
    write_reg(RegFragSize, 32'd1);
    write_reg(RegTimeout, 32'd500);
    quiet_mode = 1;
    random_part(250);
    quiet_mode = 0;
    drain();
    write_reg(RegFragSize, $urandom_range(65535, 1));
    write_reg(RegTimeout, $urandom_range(5000));
    random_part(500);
    drain();
    stim_done = 1;
    $display("%0d items sent, %0d results, %0d completions, %0d contexts expired",
             n_sent, n_results, sb.n_complete, sb.n_sweep_freed);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("fragment_reassembly_tracker verification clean");
    else
      $display("fragment_reassembly_tracker verification failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_off = 0;
      end
      out_ch.ready <= !roll_idle();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.data);
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !stim_done) begin
      $display("fragment_reassembly_tracker verification failed");
      $finish;
    end
  end

  initial begin
    n_results = 0;
    idle_cycles = 0;
  end
endmodule

// ===== fragment_reassembly_tracker.f =====
design/frt_pkg.sv
design/frt_if.sv
design/fragment_reassembly_tracker.sv
bench/fragment_reassembly_tracker_test.sv
